@@ hdl/assert_macros.svh @@
// Assertion macros used by the codec datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, suspended while reset is applied.
`define DVB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion of an implication that triggers on a condition.
`define DVB_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

@@ hdl/dvb_pkg.sv @@
// Shared constants and controller/datapath interface types of the gap codec.
`timescale 1ns / 1ps
`default_nettype none

package dvb_pkg;

  // Width of the list values; widths above the 32-bit data fields act as 32.
  localparam int VALUE_BITS = 32;
  localparam int EFF_BITS   = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
  localparam logic [31:0] VALUE_MASK =
    (EFF_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << EFF_BITS) - 32'd1);

  // Code byte layout.
  localparam int          GROUP_BITS = 7;
  localparam logic [7:0]  TOP_BIT    = 8'h80;
  localparam logic [7:0]  GROUP_MASK = 8'h7F;
  localparam logic [2:0]  MAX_GROUPS = 3'd5;
  localparam logic [2:0]  LAST_GROUP = 3'd4;

  // Mode register codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_enc;  // take a list value and form its gap
    logic accept_dec;  // take one code byte
    logic emit;        // move the next code byte into the output register
  } dvb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register is empty or being taken this cycle
    logic emit_last;   // the byte about to be emitted closes the code
  } dvb_status_t;

endpackage

`default_nettype wire

@@ hdl/dvb_ctrl.sv @@
// Controller of the gap codec: mode register and the encode byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dvb_ctrl import dvb_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i,
  input  wire         s_tvalid_i,
  output logic        s_tready_o,
  input  dvb_status_t status_i,
  output dvb_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   mode_q, mode_d;
  logic   accept;

  // Input is taken only between codes and only when a result can be stored.
  assign s_tready_o  = (state_q == ST_IDLE) && status_i.out_free;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = s_tvalid_i && s_tready_o;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    mode_d           = mode_q;
    cmd_o.accept_enc = 1'b0;
    cmd_o.accept_dec = 1'b0;
    cmd_o.emit       = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = cfg_data_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_q == MODE_ENCODE) begin
            cmd_o.accept_enc = 1'b1;
            state_d          = ST_EMIT;
          end else begin
            cmd_o.accept_dec = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_ENCODE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dvb_dpath.sv @@
// Datapath of the gap codec: predecessor, gap shifter, group gatherer and output register.
`timescale 1ns / 1ps
`default_nettype none

module dvb_dpath import dvb_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  dvb_cmd_t     cmd_i,
  output dvb_status_t  status_o,
  input  wire  [31:0]  data_in_i,
  input  wire          start_list_i,
  output logic         m_tvalid_o,
  input  wire          m_tready_i,
  output logic [31:0]  m_tdata_o,
  output logic         m_tlast_o,
  output logic         m_tuser_o
);

`include "assert_macros.svh"

  logic [31:0] next_base_q, next_base_d;
  logic [31:0] gather_q, gather_d;
  logic [2:0]  gcount_q, gcount_d;
  logic        ovl_q, ovl_d;
  logic [31:0] gap_q, gap_d;
  logic [2:0]  ecount_q, ecount_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;
  logic        out_last_q, out_last_d;
  logic        out_ovl_q, out_ovl_d;

  logic [31:0] base_eff;
  logic [31:0] value;
  logic [7:0]  code_byte;
  logic [31:0] grp_ext;
  logic [31:0] grp_placed;
  logic [31:0] gather_new;
  logic [31:0] sum;
  logic        ovl_new;
  logic        emit_last;
  logic [6:0]  emit_group;

  // Predecessor after an optional start of a new list.
  assign base_eff = start_list_i ? 32'd0 : next_base_q;
  assign value    = data_in_i & VALUE_MASK;

  // Decode: place the new group above those already gathered.
  assign code_byte = data_in_i[7:0];
  assign grp_ext   = {24'd0, code_byte & GROUP_MASK};

  always_comb begin
    case (gcount_q)
      3'd0:    grp_placed = grp_ext;
      3'd1:    grp_placed = grp_ext << GROUP_BITS;
      3'd2:    grp_placed = grp_ext << (2 * GROUP_BITS);
      3'd3:    grp_placed = grp_ext << (3 * GROUP_BITS);
      3'd4:    grp_placed = grp_ext << (4 * GROUP_BITS);
      default: grp_placed = 32'd0;
    endcase
  end

  // Earlier groups sit only below the new one, so an OR equals the sum.
  assign gather_new = (gcount_q < MAX_GROUPS) ? (gather_q | grp_placed) : gather_q;
  assign ovl_new    = (gcount_q < MAX_GROUPS) ? ovl_q : 1'b1;
  assign sum        = (gather_new + base_eff) & VALUE_MASK;

  // Encode: the byte in front of the gap shifter.
  assign emit_last  = (gap_q[31:GROUP_BITS] == '0) || (ecount_q == LAST_GROUP);
  assign emit_group = gap_q[GROUP_BITS-1:0];

  assign status_o.out_free  = !out_valid_q || m_tready_i;
  assign status_o.emit_last = emit_last;

  // Next values of the datapath registers.
  always_comb begin
    next_base_d = next_base_q;
    gather_d    = gather_q;
    gcount_d    = gcount_q;
    ovl_d       = ovl_q;
    gap_d       = gap_q;
    ecount_d    = ecount_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovl_d   = out_ovl_q;

    if (cmd_i.accept_enc) begin
      gap_d       = (value - base_eff) & VALUE_MASK;
      ecount_d    = 3'd0;
      next_base_d = (value + 32'd1) & VALUE_MASK;
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_data_d  = {24'd0, (emit_last ? TOP_BIT : 8'h00) | {1'b0, emit_group}};
      out_last_d  = emit_last;
      out_ovl_d   = 1'b0;
      gap_d       = gap_q >> GROUP_BITS;
      ecount_d    = ecount_q + 3'd1;
    end

    if (cmd_i.accept_dec) begin
      next_base_d = base_eff;
      if ((code_byte & TOP_BIT) != 8'h00) begin
        out_valid_d = 1'b1;
        out_data_d  = sum;
        out_last_d  = 1'b1;
        out_ovl_d   = ovl_new;
        next_base_d = (sum + 32'd1) & VALUE_MASK;
        gather_d    = 32'd0;
        gcount_d    = 3'd0;
        ovl_d       = 1'b0;
      end else begin
        gather_d = gather_new;
        gcount_d = (gcount_q < MAX_GROUPS) ? gcount_q + 3'd1 : gcount_q;
        ovl_d    = ovl_new;
      end
    end
  end

  // Codec state and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_base_q <= 32'd0;
      gather_q    <= 32'd0;
      gcount_q    <= 3'd0;
      ovl_q       <= 1'b0;
      ecount_q    <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      next_base_q <= next_base_d;
      gather_q    <= gather_d;
      gcount_q    <= gcount_d;
      ovl_q       <= ovl_d;
      ecount_q    <= ecount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    gap_q      <= gap_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovl_q  <= out_ovl_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_ovl_q;

  // A new result never overwrites one that is still waiting.
  `DVB_ASSERT_IMPL(a_emit_into_free, cmd_i.emit || cmd_i.accept_dec, status_o.out_free,
    "result loaded while the output register is occupied")
  // The encoder never emits more than five bytes for one value.
  `DVB_ASSERT_IMPL(a_emit_count, cmd_i.emit, ecount_q <= LAST_GROUP,
    "encoder emitted more than five bytes")
  // The group counter saturates at five.
  `DVB_ASSERT(a_gcount_range, gcount_q <= MAX_GROUPS, "group counter out of range")

endmodule

`default_nettype wire

@@ hdl/delta_varbyte_codec_core.sv @@
// Top level of the variable-byte delta gap codec for ascending integer lists.
//
//   channel  direction  signals                     payload
//   s_axis   in         tvalid tready tdata tuser   tdata: data_in; tuser: start_list
//   m_axis   out        tvalid tready tdata tlast   tdata: data_out; tlast: last;
//                       tuser                       tuser: overlong
//   cfg      in         cfg_valid/ready/data        data: mode (0 encode, 1 decode)
//
// Decode takes one byte per cycle while the output register is free.
// Encode takes a value once the prior code is emitted; codes have 1 to 5 bytes.
// The controller's byte sequencer emits one byte a cycle while the output is free.
// A stall on the output side holds the output register and blocks new input.
// Reset clears the predecessor, the group gatherer, the mode and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module delta_varbyte_codec_core import dvb_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write channel.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i,      // mode
  // Input stream.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,    // [31:0] data_in
  input  wire         s_axis_tuser,    // [0] start_list
  // Output stream.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [31:0] data_out
  output logic        m_axis_tlast,
  output logic        m_axis_tuser     // [0] overlong
);

  dvb_cmd_t    cmd;
  dvb_status_t status;

  // Mode register and byte sequencer.
  dvb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic, codec state and output register.
  dvb_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_in_i    (s_axis_tdata),
    .start_list_i (s_axis_tuser),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tlast_o    (m_axis_tlast),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire
